### sv/las_pkg.sv
// Package for the LED animation sequencer.
// Holds pattern codes, strip size constants and the frame descriptor type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package las_pkg;

    // strip size and derived widths
    localparam int PIXEL_COUNT = 16;
    localparam int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int IDX_W       = 4;

    // frame descriptor queue between front and back
    localparam int FRAME_Q_DEPTH = 2;

    // request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // pattern codes
    localparam logic [3:0] PAT_SOLID   = 4'd0;
    localparam logic [3:0] PAT_FLASH   = 4'd1;
    localparam logic [3:0] PAT_CHASE   = 4'd2;
    localparam logic [3:0] PAT_RAINBOW = 4'd3;
    localparam logic [3:0] PAT_OFF     = 4'd4;
    localparam logic [3:0] PAT_WARMUP  = 4'd5;
    localparam logic [3:0] PAT_PULSE   = 4'd6;
    localparam logic [3:0] PAT_BREATHE = 4'd7;
    localparam logic [3:0] PAT_CELEB   = 4'd8;

    // one frame to be drawn by the back end
    typedef struct packed {
        logic [3:0]  pattern;
        logic [23:0] color;
        logic [7:0]  step;
        logic        half;
        logic        last;
    } t_frame;

endpackage

`default_nettype wire

### sv/las_frame_queue.sv
// Short frame descriptor queue between the front and back ends.
// Depends on las_pkg (t_frame, FRAME_Q_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module las_frame_queue
    import las_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_data
);

    localparam int PTR_W = (FRAME_Q_DEPTH > 1) ? $clog2(FRAME_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(FRAME_Q_DEPTH + 1);

    t_frame             r_mem [FRAME_Q_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(FRAME_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(FRAME_Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(FRAME_Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_Q_DEPTH))
        else $error("frame queue count above depth");
`endif

endmodule

`default_nettype wire

### sv/las_front.sv
// Front end: accepts start and tick requests, keeps the pattern state and
// queues one descriptor per frame to draw. Depends on las_pkg.
`timescale 1ns / 1ps
`default_nettype none

module las_front
    import las_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_q_full,
    input  logic        i_kind,
    input  logic [3:0]  i_pattern_code,
    input  logic [23:0] i_rgb_color,
    output logic        o_frame_push,
    output t_frame      o_frame
);

    // inter-frame delays in milliseconds
    localparam logic [7:0] DLY_FLASH   = 8'd150;
    localparam logic [7:0] DLY_CHASE   = 8'd50;
    localparam logic [7:0] DLY_RAINBOW = 8'd10;
    localparam logic [7:0] DLY_WARMUP  = 8'd50;
    localparam logic [7:0] DLY_PULSE   = 8'd200;
    localparam logic [7:0] DLY_BREATHE = 8'd80;
    localparam logic [7:0] DLY_CELEB   = 8'd20;
    localparam logic [7:0] DLY_DEFAULT = 8'd1;

    logic        r_busy;
    logic [3:0]  r_pat;
    logic [23:0] r_color;
    logic [2:0]  r_rc;
    logic [7:0]  r_step;
    logic        r_half;
    logic [7:0]  r_wait;

    logic        n_busy;
    logic [7:0]  n_wait;

    // state after start or advance
    logic [3:0]  a_pat;
    logic [23:0] a_color;
    logic [2:0]  a_rc;
    logic [7:0]  a_step;
    logic        a_half;
    logic        a_last;
    logic        emit;
    logic        accept;
    logic [2:0]  rc_inc;
    logic [7:0]  step_inc;

    function automatic logic [7:0] frame_delay(input logic [3:0] pat);
        logic [7:0] d;
        unique case (pat)
            PAT_FLASH:   d = DLY_FLASH;
            PAT_CHASE:   d = DLY_CHASE;
            PAT_RAINBOW: d = DLY_RAINBOW;
            PAT_WARMUP:  d = DLY_WARMUP;
            PAT_PULSE:   d = DLY_PULSE;
            PAT_BREATHE: d = DLY_BREATHE;
            PAT_CELEB:   d = DLY_CELEB;
            default:     d = DLY_DEFAULT;
        endcase
        return d;
    endfunction

    function automatic logic is_last(input logic [3:0] pat, input logic [2:0] rc,
                                     input logic half, input logic [7:0] step);
        logic l;
        unique case (pat)
            PAT_FLASH:   l = (rc >= 3'd2) && half;
            PAT_PULSE:   l = (rc >= 3'd4) && half;
            PAT_CHASE,
            PAT_RAINBOW,
            PAT_CELEB:   l = half;
            PAT_WARMUP:  l = half && (step <= 8'd50);
            PAT_BREATHE: l = (rc >= 3'd2) && half && (step == 8'd0);
            default:     l = 1'b1;
        endcase
        return l;
    endfunction

    assign accept   = i_push && !i_q_full;
    assign rc_inc   = r_rc + 3'd1;
    assign step_inc = r_step + 8'd1;

    // start a pattern or step the running one
    always_comb begin
        a_pat   = r_pat;
        a_color = r_color;
        a_rc    = r_rc;
        a_step  = r_step;
        a_half  = r_half;
        emit    = 1'b0;
        if (accept) begin
            if (i_kind == KIND_START) begin
                if (i_pattern_code <= PAT_CELEB) begin
                    a_pat   = i_pattern_code;
                    a_color = i_rgb_color;
                    a_rc    = '0;
                    a_half  = 1'b0;
                    a_step  = (i_pattern_code == PAT_WARMUP) ? 8'd50 : 8'd0;
                    emit    = 1'b1;
                end
            end else if (r_busy && r_wait <= 8'd1) begin
                emit = 1'b1;
                unique case (r_pat)
                    PAT_FLASH, PAT_PULSE: begin
                        a_half = !r_half;
                        if (r_half) a_rc = rc_inc;
                    end
                    PAT_CHASE: begin
                        if (step_inc >= 8'(PIXEL_COUNT)) begin
                            a_step = '0;
                            a_rc   = rc_inc;
                            if (rc_inc >= 3'd3) a_half = 1'b1;
                        end else begin
                            a_step = step_inc;
                        end
                    end
                    PAT_RAINBOW: begin
                        if (r_step == 8'd255) a_half = 1'b1;
                        else a_step = step_inc;
                    end
                    PAT_WARMUP: begin
                        if (!r_half) begin
                            if (r_step >= 8'd150) a_half = 1'b1;
                            else a_step = r_step + 8'd10;
                        end else begin
                            a_step = r_step - 8'd10;
                        end
                    end
                    PAT_BREATHE: begin
                        if (!r_half) begin
                            if (r_step >= 8'd100) a_half = 1'b1;
                            else a_step = r_step + 8'd5;
                        end else if (r_step == 8'd0) begin
                            a_half = 1'b0;
                            a_rc   = rc_inc;
                        end else begin
                            a_step = r_step - 8'd5;
                        end
                    end
                    PAT_CELEB: begin
                        if (r_step >= 8'd248) begin
                            a_step = '0;
                            a_rc   = rc_inc;
                            if (rc_inc >= 3'd3) a_half = 1'b1;
                        end else begin
                            a_step = r_step + 8'd8;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // busy flag and delay counter
    always_comb begin
        a_last = is_last(a_pat, a_rc, a_half, a_step);
        n_busy = r_busy;
        n_wait = r_wait;
        if (emit) begin
            n_busy = !a_last;
            n_wait = a_last ? 8'd0 : frame_delay(a_pat);
        end else if (accept && i_kind == KIND_TICK && r_busy) begin
            n_wait = r_wait - 8'd1;
        end
    end

    assign o_frame_push    = emit;
    assign o_frame.pattern = a_pat;
    assign o_frame.color   = a_color;
    assign o_frame.step    = a_step;
    assign o_frame.half    = a_half;
    assign o_frame.last    = a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pat   <= PAT_SOLID;
            r_color <= '0;
            r_rc    <= '0;
            r_step  <= '0;
            r_half  <= 1'b0;
            r_wait  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_pat   <= a_pat;
            r_color <= a_color;
            r_rc    <= a_rc;
            r_step  <= a_step;
            r_half  <= a_half;
            r_wait  <= n_wait;
        end
    end

`ifndef SYNTHESIS
    a_busy_has_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_wait != 8'd0))
        else $error("busy with no delay pending");
`endif

endmodule

`default_nettype wire

### sv/las_back.sv
// Back end: walks each queued frame pixel by pixel and holds the result
// register toward the output side. Depends on las_pkg.
`timescale 1ns / 1ps
`default_nettype none

module las_back
    import las_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_frame           i_frame,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [IDX_W-1:0] o_pixel_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_frame_end,
    output logic             o_pattern_finished
);

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

    logic             r_out_valid;
    logic [PIX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [23:0]      r_rgb;
    logic             r_end;
    logic             r_fin;
    logic             load;
    logic             cnt_last;
    logic [23:0]      pix_rgb;

    // color wheel: red-green-blue over 256 positions
    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [9:0] q3;
        logic [23:0] c;
        p = 8'd255 - pos;
        if (p < WHEEL_SEG1) begin
            q  = p;
            q3 = 10'(q) * 10'd3;
            c  = {8'd255 - q3[7:0], 8'd0, q3[7:0]};
        end else if (p < WHEEL_SEG2) begin
            q  = p - WHEEL_SEG1;
            q3 = 10'(q) * 10'd3;
            c  = {8'd0, q3[7:0], 8'd255 - q3[7:0]};
        end else begin
            q  = p - WHEEL_SEG2;
            q3 = 10'(q) * 10'd3;
            c  = {q3[7:0], 8'd255 - q3[7:0], 8'd0};
        end
        return c;
    endfunction

    function automatic logic [23:0] pixel_color(input t_frame f, input logic [7:0] i);
        logic [23:0] c;
        unique case (f.pattern)
            PAT_SOLID:            c = f.color;
            PAT_FLASH, PAT_PULSE: c = f.half ? 24'd0 : f.color;
            PAT_CHASE:            c = (f.half || i != f.step) ? 24'd0 : f.color;
            PAT_RAINBOW,
            PAT_CELEB:            c = f.half ? 24'd0 : wheel(i + f.step);
            PAT_WARMUP:           c = {f.step, 1'b0, f.step[7:1], 8'd0};
            PAT_BREATHE:          c = {16'd0, f.step};
            default:              c = 24'd0;
        endcase
        return c;
    endfunction

    assign load     = i_q_valid && (!r_out_valid || i_pop);
    assign cnt_last = (r_cnt == PIX_LAST);
    assign o_q_pop  = load && cnt_last;
    assign pix_rgb  = pixel_color(i_frame, 8'(r_cnt));

    // pixel counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_cnt       <= cnt_last ? '0 : r_cnt + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx <= IDX_W'(r_cnt);
            r_rgb <= pix_rgb;
            r_end <= cnt_last;
            r_fin <= i_frame.last;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_pixel_index      = r_idx;
    assign o_red              = r_rgb[23:16];
    assign o_green            = r_rgb[15:8];
    assign o_blue             = r_rgb[7:0];
    assign o_frame_end        = r_end;
    assign o_pattern_finished = r_fin;

`ifndef SYNTHESIS
    a_mid_frame_has_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> i_q_valid)
        else $error("pixel walk without a frame descriptor");
    a_end_on_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_end) |-> (r_idx == IDX_W'(PIX_LAST)))
        else $error("frame end on a pixel that is not the last");
    a_next_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && cnt_last) |=> (r_cnt == '0))
        else $error("pixel counter did not wrap after frame end");
`endif

endmodule

`default_nettype wire

### sv/led_animation_sequencer_unit.sv
// LED animation sequencer, top level.
// Instantiates las_front, las_frame_queue and las_back; uses las_pkg.
// Usage:
//   Request side is a queue write port: push with i_kind, i_pattern_code
//   and i_rgb_color, taken on a clock edge where full is low. Kind start
//   selects a pattern and draws its first frame; kind tick is one
//   millisecond and draws the next frame when the pattern's delay runs out.
//   Result side is a queue read port: while empty is low the oldest pixel
//   is on the result ports, taken on an edge with pop high.
//   Each frame is PIXEL_COUNT pixels, pixel 0 first, o_frame_end on the last
//   one, o_pattern_finished on every pixel of a pattern's final frame.
// Timing:
//   The front end takes one request per cycle while full is low. A request
//   that draws a frame puts it in a two-entry frame queue; with the back
//   end idle its first pixel passes through the frame queue and then the
//   result register to the ports. The back end emits one pixel per cycle
//   while pop keeps the result register free. When the receiver stalls
//   the result register holds, the frame queue fills and full rises.
// Reset: i_rst_n low on an edge clears the sequencer to idle, empties both
//   queues and discards any frame in progress.
`timescale 1ns / 1ps
`default_nettype none

module led_animation_sequencer_unit
    import las_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic             i_kind,
    input  logic [3:0]       i_pattern_code,
    input  logic [23:0]      i_rgb_color,
    output logic             empty,
    input  logic             pop,
    output logic [IDX_W-1:0] o_pixel_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_frame_end,
    output logic             o_pattern_finished
);

    logic   frame_push;
    t_frame frame_in;
    logic   q_full;
    logic   q_valid;
    t_frame q_frame;
    logic   q_pop;

    assign full = q_full;

    // request decode and pattern state
    las_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_q_full       (q_full),
        .i_kind         (i_kind),
        .i_pattern_code (i_pattern_code),
        .i_rgb_color    (i_rgb_color),
        .o_frame_push   (frame_push),
        .o_frame        (frame_in)
    );

    // frames waiting to be drawn
    las_frame_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (frame_push),
        .i_data  (frame_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_frame)
    );

    // pixel generation and result register
    las_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_frame            (q_frame),
        .o_q_pop            (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_pixel_index      (o_pixel_index),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .o_frame_end        (o_frame_end),
        .o_pattern_finished (o_pattern_finished)
    );

endmodule

`default_nettype wire
